// ----- rtl/core/brz_pkg.sv -----
`timescale 1ns / 1ps

package brz_pkg;

  // one input word: a source pixel write or a destination pixel request
  typedef struct packed {
    logic        req_type;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic [7:0]  chan_zero;
    logic [7:0]  chan_one;
    logic [7:0]  chan_two;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic [11:0] out_col;
    logic [11:0] out_row;
    logic [7:0]  out_chan_zero;
    logic [7:0]  out_chan_one;
    logic [7:0]  out_chan_two;
  } out_word_t;

  // control that travels with a request from address stage to blend stage
  typedef struct packed {
    logic        valid;
    logic [11:0] col;
    logic [11:0] row;
    logic        x_odd;
    logic        y_odd;
    logic        dx;
    logic        dy;
  } map_ctl_t;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // register map (index = paddr / 4)
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_HSTEP      = 3'd2;
  localparam logic [2:0] REG_VSTEP      = 3'd3;
  localparam logic [2:0] REG_COLOR_MODE = 3'd4;

  localparam logic [8:0]  RST_SRC_WIDTH  = 9'd256;
  localparam logic [8:0]  RST_SRC_HEIGHT = 9'd256;
  localparam logic [23:0] RST_STEP       = 24'd65536;
  localparam logic        RST_COLOR_MODE = 1'b1;

  localparam int PixW = 24;

endpackage

// ----- rtl/core/brz_ram.sv -----
`timescale 1ns / 1ps

module brz_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while disabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/brz_map.sv -----
`timescale 1ns / 1ps

module brz_map #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int FRAC_BITS      = 16,
  localparam int HalfW  = (MAX_SRC_WIDTH + 1) / 2,
  localparam int HalfH  = (MAX_SRC_HEIGHT + 1) / 2,
  localparam int Hx     = (HalfW > 1) ? $clog2(HalfW) : 1,
  localparam int Hy     = (HalfH > 1) ? $clog2(HalfH) : 1,
  localparam int BankAw = Hx + Hy
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        in_valid_i,
  input  brz_pkg::in_word_t           in_word_i,
  input  logic [8:0]                  src_width_i,
  input  logic [8:0]                  src_height_i,
  input  logic [23:0]                 hstep_i,
  input  logic [23:0]                 vstep_i,
  output logic [3:0]                  we_o,
  output logic [BankAw-1:0]           waddr_o,
  output logic [brz_pkg::PixW-1:0]    wdata_o,
  output logic [3:0][BankAw-1:0]      raddr_o,
  output brz_pkg::map_ctl_t           ctl_o,
  output logic [FRAC_BITS-1:0]        fx_o,
  output logic [FRAC_BITS-1:0]        fy_o
);

  localparam int ProdW = 36;
  localparam int IntW  = ProdW - FRAC_BITS;
  localparam int Xw    = $clog2(MAX_SRC_WIDTH);
  localparam int Yw    = $clog2(MAX_SRC_HEIGHT);

  // stage 1: coordinate products
  logic                    s1_valid_q;
  logic                    s1_req_q;
  logic [11:0]             s1_col_q, s1_row_q;
  logic [brz_pkg::PixW-1:0] s1_pix_q;
  logic [ProdW-1:0]        s1_sx_q, s1_sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_req_q <= in_word_i.req_type;
      s1_col_q <= in_word_i.pixel_col;
      s1_row_q <= in_word_i.pixel_row;
      s1_pix_q <= {in_word_i.chan_two, in_word_i.chan_one, in_word_i.chan_zero};
      s1_sx_q  <= ProdW'(in_word_i.pixel_col) * ProdW'(hstep_i);
      s1_sy_q  <= ProdW'(in_word_i.pixel_row) * ProdW'(vstep_i);
    end
  end

  // source size clamp
  logic [12:0] w_c, h_c, w_m1, h_m1;

  always_comb begin
    if (src_width_i == 9'd0) begin
      w_c = 13'd1;
    end else if (13'(src_width_i) > 13'(MAX_SRC_WIDTH)) begin
      w_c = 13'(MAX_SRC_WIDTH);
    end else begin
      w_c = 13'(src_width_i);
    end
    if (src_height_i == 9'd0) begin
      h_c = 13'd1;
    end else if (13'(src_height_i) > 13'(MAX_SRC_HEIGHT)) begin
      h_c = 13'(MAX_SRC_HEIGHT);
    end else begin
      h_c = 13'(src_height_i);
    end
    w_m1 = w_c - 13'd1;
    h_m1 = h_c - 13'd1;
  end

  // neighbor coordinates, clamped at the frame edge
  logic [IntW:0] px, py, px1, py1, wme, hme, x0e, x1e, y0e, y1e;
  logic [Xw-1:0] x0, x1;
  logic [Yw-1:0] y0, y1;

  always_comb begin
    px  = (IntW+1)'(s1_sx_q[ProdW-1:FRAC_BITS]);
    py  = (IntW+1)'(s1_sy_q[ProdW-1:FRAC_BITS]);
    px1 = px + (IntW+1)'(1);
    py1 = py + (IntW+1)'(1);
    wme = (IntW+1)'(w_m1);
    hme = (IntW+1)'(h_m1);
    x0e = (px  < wme) ? px  : wme;
    x1e = (px1 < wme) ? px1 : wme;
    y0e = (py  < hme) ? py  : hme;
    y1e = (py1 < hme) ? py1 : hme;
    x0  = x0e[Xw-1:0];
    x1  = x1e[Xw-1:0];
    y0  = y0e[Yw-1:0];
    y1  = y1e[Yw-1:0];
  end

  // four banks by row and column parity; bank index = {row odd, col odd}
  logic [Xw-1:0] col_sel;
  logic [Yw-1:0] row_sel;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      col_sel = (x0[0] == b[0]) ? x0 : x1;
      row_sel = (y0[0] == b[1]) ? y0 : y1;
      raddr_o[b] = {Hy'(row_sel >> 1), Hx'(col_sel >> 1)};
    end
  end

  // pixel write into its bank
  logic in_range;

  always_comb begin
    in_range = (13'(s1_col_q) < 13'(MAX_SRC_WIDTH)) &&
               (13'(s1_row_q) < 13'(MAX_SRC_HEIGHT));
    for (int b = 0; b < 4; b++) begin
      we_o[b] = en_i && s1_valid_q && (s1_req_q == brz_pkg::REQ_WRITE) && in_range &&
                (s1_row_q[0] == b[1]) && (s1_col_q[0] == b[0]);
    end
    waddr_o = {Hy'(s1_row_q >> 1), Hx'(s1_col_q >> 1)};
    wdata_o = s1_pix_q;
  end

  // stage 2: aligned with the bank read data
  brz_pkg::map_ctl_t s2_ctl_q;
  logic [FRAC_BITS-1:0] s2_fx_q, s2_fy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else if (en_i) begin
      s2_ctl_q.valid <= s1_valid_q && (s1_req_q == brz_pkg::REQ_READ);
      s2_ctl_q.col   <= s1_col_q;
      s2_ctl_q.row   <= s1_row_q;
      s2_ctl_q.x_odd <= x0[0];
      s2_ctl_q.y_odd <= y0[0];
      s2_ctl_q.dx    <= (x0 != x1);
      s2_ctl_q.dy    <= (y0 != y1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_fx_q <= s1_sx_q[FRAC_BITS-1:0];
      s2_fy_q <= s1_sy_q[FRAC_BITS-1:0];
    end
  end

  assign ctl_o = s2_ctl_q;
  assign fx_o  = s2_fx_q;
  assign fy_o  = s2_fy_q;

`ifndef SYNTHESIS
  // a written pixel goes to one bank at most
  a_one_bank: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(we_o))
    else $error("pixel write hits more than one bank");
  // right neighbor is the left one or the next column
  a_x_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (x1 == x0) || (x1 == x0 + Xw'(1)))
    else $error("column pair not adjacent");
`endif

endmodule

// ----- rtl/core/brz_blend.sv -----
`timescale 1ns / 1ps

module brz_blend #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  brz_pkg::map_ctl_t             ctl_i,
  input  logic [FRAC_BITS-1:0]          fx_i,
  input  logic [FRAC_BITS-1:0]          fy_i,
  input  logic [3:0][brz_pkg::PixW-1:0] bank_i,
  input  logic                          color_mode_i,
  output logic                          out_valid_o,
  output brz_pkg::out_word_t            out_word_o
);

  localparam int Tw = FRAC_BITS + 9;
  localparam int Sw = 2 * FRAC_BITS + 10;
  localparam logic [Tw-1:0] One    = Tw'(1) << FRAC_BITS;
  localparam logic [Sw-1:0] OneS   = Sw'(1) << FRAC_BITS;
  localparam logic [Sw-1:0] Half   = Sw'(1) << (2 * FRAC_BITS - 1);
  localparam logic [Sw-1:0] MaxSum = Sw'(255) << (2 * FRAC_BITS);

  // pick the four neighbors out of the parity banks
  logic [brz_pkg::PixW-1:0] p00, p01, p10, p11;

  always_comb begin
    p00 = bank_i[{ctl_i.y_odd,            ctl_i.x_odd}];
    p01 = bank_i[{ctl_i.y_odd,            ctl_i.x_odd ^ ctl_i.dx}];
    p10 = bank_i[{ctl_i.y_odd ^ ctl_i.dy, ctl_i.x_odd}];
    p11 = bank_i[{ctl_i.y_odd ^ ctl_i.dy, ctl_i.x_odd ^ ctl_i.dx}];
  end

  // stage 3: horizontal blend of top and bottom rows
  logic          s3_valid_q;
  logic [11:0]   s3_col_q, s3_row_q;
  logic [FRAC_BITS-1:0] s3_fy_q;
  logic [Tw-1:0] top_d [3];
  logic [Tw-1:0] bot_d [3];
  logic [Tw-1:0] top_q [3];
  logic [Tw-1:0] bot_q [3];
  logic [Tw-1:0] wx0;

  always_comb begin
    wx0 = One - Tw'(fx_i);
    for (int c = 0; c < 3; c++) begin
      top_d[c] = wx0 * Tw'(p00[8*c +: 8]) + Tw'(fx_i) * Tw'(p01[8*c +: 8]);
      bot_d[c] = wx0 * Tw'(p10[8*c +: 8]) + Tw'(fx_i) * Tw'(p11[8*c +: 8]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_col_q <= ctl_i.col;
      s3_row_q <= ctl_i.row;
      s3_fy_q  <= fy_i;
      for (int c = 0; c < 3; c++) begin
        top_q[c] <= top_d[c];
        bot_q[c] <= bot_d[c];
      end
    end
  end

  // stage 4: vertical blend
  logic          s4_valid_q;
  logic [11:0]   s4_col_q, s4_row_q;
  logic [Sw-1:0] sum_d [3];
  logic [Sw-1:0] sum_q [3];
  logic [Sw-1:0] wy0;

  always_comb begin
    wy0 = OneS - Sw'(s3_fy_q);
    for (int c = 0; c < 3; c++) begin
      sum_d[c] = wy0 * Sw'(top_q[c]) + Sw'(s3_fy_q) * Sw'(bot_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_col_q <= s3_col_q;
      s4_row_q <= s3_row_q;
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= sum_d[c];
      end
    end
  end

  // output stage: round half up, saturate, gray mode masks channels one and two
  logic [Sw-1:0] rnd [3];
  logic [7:0]    ch  [3];
  logic          out_valid_q;
  brz_pkg::out_word_t out_word_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rnd[c] = (sum_q[c] + Half) >> (2 * FRAC_BITS);
      ch[c]  = (rnd[c] > Sw'(255)) ? 8'hff : rnd[c][7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_word_q.out_col       <= s4_col_q;
      out_word_q.out_row       <= s4_row_q;
      out_word_q.out_chan_zero <= ch[0];
      out_word_q.out_chan_one  <= color_mode_i ? ch[1] : 8'd0;
      out_word_q.out_chan_two  <= color_mode_i ? ch[2] : 8'd0;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q  <= ctl_i.valid;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  // blend weights sum to one, so the sum never passes full scale
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q |-> (sum_q[0] <= MaxSum) && (sum_q[1] <= MaxSum) && (sum_q[2] <= MaxSum))
    else $error("blend sum above full scale");
`endif

endmodule

// ----- rtl/core/bilinear_image_resize.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake             word
// in        input      in_valid_i/in_stall_o  brz_pkg::in_word_t
// out       output     out_valid_o/out_stall_i brz_pkg::out_word_t
// apb       input      psel/penable/pready    32-bit registers at 4*index
//
// one word per cycle while no result is stalled; a request's result is registered through
// the multiply, bank read, two blend multiply and output stages
// reset loads the register defaults and clears the valid bits; the frame store is not cleared
// a stalled result stalls the whole pipeline and the input with it

module bilinear_image_resize #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int FRAC_BITS      = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  brz_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output brz_pkg::out_word_t out_word_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int HalfW  = (MAX_SRC_WIDTH + 1) / 2;
  localparam int HalfH  = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int Hx     = (HalfW > 1) ? $clog2(HalfW) : 1;
  localparam int Hy     = (HalfH > 1) ? $clog2(HalfH) : 1;
  localparam int BankAw = Hx + Hy;

  // configuration registers
  logic [8:0]  src_width_q, src_height_q;
  logic [23:0] hstep_q, vstep_q;
  logic        color_mode_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= brz_pkg::RST_SRC_WIDTH;
      src_height_q <= brz_pkg::RST_SRC_HEIGHT;
      hstep_q      <= brz_pkg::RST_STEP;
      vstep_q      <= brz_pkg::RST_STEP;
      color_mode_q <= brz_pkg::RST_COLOR_MODE;
    end else if (cfg_wr) begin
      case (reg_idx)
        brz_pkg::REG_SRC_WIDTH:  src_width_q  <= pwdata[8:0];
        brz_pkg::REG_SRC_HEIGHT: src_height_q <= pwdata[8:0];
        brz_pkg::REG_HSTEP:      hstep_q      <= pwdata[23:0];
        brz_pkg::REG_VSTEP:      vstep_q      <= pwdata[23:0];
        brz_pkg::REG_COLOR_MODE: color_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (reg_idx)
      brz_pkg::REG_SRC_WIDTH:  prdata = 32'(src_width_q);
      brz_pkg::REG_SRC_HEIGHT: prdata = 32'(src_height_q);
      brz_pkg::REG_HSTEP:      prdata = 32'(hstep_q);
      brz_pkg::REG_VSTEP:      prdata = 32'(vstep_q);
      brz_pkg::REG_COLOR_MODE: prdata = 32'(color_mode_q);
      default:                 prdata = 32'd0;
    endcase
  end

  // pipeline advances unless a result waits
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // address stage
  logic [3:0]                  we;
  logic [BankAw-1:0]           waddr;
  logic [brz_pkg::PixW-1:0]    wdata;
  logic [3:0][BankAw-1:0]      raddr;
  logic [3:0][brz_pkg::PixW-1:0] rdata;
  brz_pkg::map_ctl_t           ctl;
  logic [FRAC_BITS-1:0]        fx, fy;

  brz_map #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
    .FRAC_BITS     (FRAC_BITS)
  ) u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .src_width_i (src_width_q),
    .src_height_i(src_height_q),
    .hstep_i     (hstep_q),
    .vstep_i     (vstep_q),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .ctl_o       (ctl),
    .fx_o        (fx),
    .fy_o        (fy)
  );

  // frame store: four parity banks
  for (genvar b = 0; b < 4; b++) begin : g_bank
    brz_ram #(
      .WIDTH(brz_pkg::PixW),
      .DEPTH(2 ** BankAw)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (we[b]),
      .waddr_i(waddr),
      .wdata_i(wdata),
      .re_i   (en),
      .raddr_i(raddr[b]),
      .rdata_o(rdata[b])
    );
  end

  // blend stages
  brz_blend #(
    .FRAC_BITS(FRAC_BITS)
  ) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctl_i       (ctl),
    .fx_i        (fx),
    .fy_i        (fy),
    .bank_i      (rdata),
    .color_mode_i(color_mode_q),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

`ifndef SYNTHESIS
  // gray mode results carry zero in channels one and two
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !color_mode_q) |->
      (out_word_o.out_chan_one == 8'd0) && (out_word_o.out_chan_two == 8'd0))
    else $error("gray result with color channels");
`endif

endmodule

// ----- bench/tb_bilinear_image_resize.sv -----
`timescale 1ns / 1ps

module tb_bilinear_image_resize;

  localparam int StoreW = 256;
  localparam int StoreH = 256;
  localparam int Frac = 16;
  localparam int CycleLimit = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  brz_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  brz_pkg::out_word_t out_word;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bilinear_image_resize dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_word_o(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the registers and the frame store
  logic [8:0] src_w = brz_pkg::RST_SRC_WIDTH;
  logic [8:0] src_h = brz_pkg::RST_SRC_HEIGHT;
  logic [23:0] h_step = brz_pkg::RST_STEP;
  logic [23:0] v_step = brz_pkg::RST_STEP;
  logic color = brz_pkg::RST_COLOR_MODE;
  logic [23:0] frame_copy [StoreW*StoreH];

  brz_pkg::out_word_t pixel_q [$];
  int idle_pct = 0;
  int stall_pct = 0;
  int err_cnt = 0;
  int px_written = 0;
  int px_checked = 0;
  int cyc = 0;

  // directed rows: register write, or word with optional hand-typed result
  typedef struct {
    bit        is_reg;
    logic [2:0] reg_idx;
    logic [31:0] reg_val;
    brz_pkg::in_word_t  w;
    bit        typed;
    brz_pkg::out_word_t exp;
  } dir_row_t;
  dir_row_t dir_tab [$];

  function automatic logic [7:0] blend_chan(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                            logic [7:0] d, longint unsigned fx,
                                            longint unsigned fy);
    longint unsigned one, sum, r;
    one = 64'd1 << Frac;
    sum = (one - fx) * (one - fy) * a + fx * (one - fy) * b
        + (one - fx) * fy * c + fx * fy * d;
    r = (sum + (64'd1 << (2 * Frac - 1))) >> (2 * Frac);
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic longint unsigned eff_size(logic [8:0] v, int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic brz_pkg::out_word_t predict_pixel(logic [11:0] col, logic [11:0] row);
    longint unsigned w, h, sx, sy, px, py, fx, fy, x0, x1, y0, y1;
    logic [23:0] p00, p01, p10, p11;
    brz_pkg::out_word_t o;
    w = eff_size(src_w, StoreW);
    h = eff_size(src_h, StoreH);
    sx = col * h_step;
    sy = row * v_step;
    px = sx >> Frac;
    py = sy >> Frac;
    fx = sx & ((64'd1 << Frac) - 1);
    fy = sy & ((64'd1 << Frac) - 1);
    x0 = (px < w - 1) ? px : w - 1;
    x1 = (px + 1 < w - 1) ? px + 1 : w - 1;
    y0 = (py < h - 1) ? py : h - 1;
    y1 = (py + 1 < h - 1) ? py + 1 : h - 1;
    p00 = frame_copy[y0 * StoreW + x0];
    p01 = frame_copy[y0 * StoreW + x1];
    p10 = frame_copy[y1 * StoreW + x0];
    p11 = frame_copy[y1 * StoreW + x1];
    o.out_col = col;
    o.out_row = row;
    o.out_chan_zero = blend_chan(p00[7:0], p01[7:0], p10[7:0], p11[7:0], fx, fy);
    o.out_chan_one = color ? blend_chan(p00[15:8], p01[15:8], p10[15:8], p11[15:8], fx, fy)
                           : 8'd0;
    o.out_chan_two = color ? blend_chan(p00[23:16], p01[23:16], p10[23:16], p11[23:16],
                                        fx, fy) : 8'd0;
    return o;
  endfunction

  // drive one word, then update the shadow store or queue the result
  task automatic send_word(brz_pkg::in_word_t w, bit typed = 0,
                           brz_pkg::out_word_t exp = '0);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    if (w.req_type == brz_pkg::REQ_WRITE) begin
      if (w.pixel_col < StoreW && w.pixel_row < StoreH)
        frame_copy[w.pixel_row * StoreW + w.pixel_col] = {w.chan_two, w.chan_one, w.chan_zero};
    end else begin
      pixel_q.push_back(typed ? exp : predict_pixel(w.pixel_col, w.pixel_row));
    end
  endtask

  // let the pipeline drain, including trailing writes
  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      brz_pkg::REG_SRC_WIDTH: src_w = val[8:0];
      brz_pkg::REG_SRC_HEIGHT: src_h = val[8:0];
      brz_pkg::REG_HSTEP: h_step = val[23:0];
      brz_pkg::REG_VSTEP: v_step = val[23:0];
      brz_pkg::REG_COLOR_MODE: color = val[0];
      default: ;
    endcase
  endtask

  function automatic brz_pkg::in_word_t wr_word(int c, int r, logic [23:0] px);
    return '{brz_pkg::REQ_WRITE, 12'(c), 12'(r), px[7:0], px[15:8], px[23:16]};
  endfunction

  function automatic brz_pkg::in_word_t rd_word(int c, int r);
    brz_pkg::in_word_t w;
    w = '{brz_pkg::REQ_READ, 12'(c), 12'(r), 8'($urandom), 8'($urandom), 8'($urandom)};
    return w;
  endfunction

  function automatic brz_pkg::out_word_t px_res(int c, int r, logic [7:0] a, logic [7:0] b,
                                                logic [7:0] d);
    return '{12'(c), 12'(r), a, b, d};
  endfunction

  task automatic add_reg(logic [2:0] idx, logic [31:0] val);
    dir_row_t row;
    row = '{1, idx, val, '0, 0, '0};
    dir_tab.push_back(row);
  endtask

  task automatic add_word(brz_pkg::in_word_t w, bit typed = 0,
                          brz_pkg::out_word_t exp = '0);
    dir_row_t row;
    row = '{0, brz_pkg::REG_SRC_WIDTH, 0, w, typed, exp};
    dir_tab.push_back(row);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected result col %0d row %0d", $time, out_word.out_col,
                 out_word.out_row);
        err_cnt++;
      end else begin
        brz_pkg::out_word_t e;
        e = pixel_q.pop_front();
        px_checked++;
        if (out_word !== e) begin
          $display({"%0t: mismatch expected col %0d row %0d ch %h %h %h, ",
                    "got col %0d row %0d ch %h %h %h"},
                   $time, e.out_col, e.out_row, e.out_chan_zero, e.out_chan_one,
                   e.out_chan_two, out_word.out_col, out_word.out_row,
                   out_word.out_chan_zero, out_word.out_chan_one, out_word.out_chan_two);
          err_cnt++;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cyc++;
    if (cyc >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int ew, eh, r, c;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 2x2 frame, edge clamping, ignored writes, gray mode at half step
    add_reg(brz_pkg::REG_SRC_WIDTH, 2);
    add_reg(brz_pkg::REG_SRC_HEIGHT, 2);
    add_word(wr_word(0, 0, 24'h8000ff));
    add_word(wr_word(1, 0, 24'h7fff00));
    add_word(wr_word(0, 1, 24'h030201));
    add_word(wr_word(1, 1, 24'hfcfdfe));
    add_word(wr_word(4095, 4095, 24'h555555));
    add_word(wr_word(256, 0, 24'haaaaaa));
    add_word(wr_word(0, 256, 24'haaaaaa));
    add_word(rd_word(0, 0), 1, px_res(0, 0, 8'hff, 8'h00, 8'h80));
    add_word(rd_word(1, 0), 1, px_res(1, 0, 8'h00, 8'hff, 8'h7f));
    add_word(rd_word(1, 1), 1, px_res(1, 1, 8'hfe, 8'hfd, 8'hfc));
    add_word(rd_word(4095, 4095), 1, px_res(4095, 4095, 8'hfe, 8'hfd, 8'hfc));
    add_reg(brz_pkg::REG_HSTEP, 32768);
    add_reg(brz_pkg::REG_VSTEP, 32768);
    add_reg(brz_pkg::REG_COLOR_MODE, 0);
    add_word(rd_word(1, 1), 1, px_res(1, 1, 8'd128, 8'd0, 8'd0));
    add_word(rd_word(2, 0));
    add_word(rd_word(0, 3));
    add_reg(brz_pkg::REG_HSTEP, 0);
    add_reg(brz_pkg::REG_VSTEP, 24'hffffff);
    add_reg(brz_pkg::REG_COLOR_MODE, 1);
    add_word(rd_word(4095, 1));
    add_word(rd_word(1, 0));
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_reg) reg_write(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      else send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].exp);
    end

    // random phases: load a frame, then requests mixed with rewrites and stray writes
    for (int p = 0; p < 10; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      if (p == 0) begin
        reg_write(brz_pkg::REG_SRC_WIDTH, 256);
        reg_write(brz_pkg::REG_SRC_HEIGHT, 0);
      end else if (p == 1) begin
        reg_write(brz_pkg::REG_SRC_WIDTH, 0);
        reg_write(brz_pkg::REG_SRC_HEIGHT, 511);
      end else begin
        reg_write(brz_pkg::REG_SRC_WIDTH, $urandom_range(2, 8));
        reg_write(brz_pkg::REG_SRC_HEIGHT, $urandom_range(2, 8));
      end
      case (p % 5)
        0: begin
          reg_write(brz_pkg::REG_HSTEP, 0);
          reg_write(brz_pkg::REG_VSTEP, 24'hffffff);
        end
        1: begin
          reg_write(brz_pkg::REG_HSTEP, 1);
          reg_write(brz_pkg::REG_VSTEP, 65536);
        end
        default: begin
          reg_write(brz_pkg::REG_HSTEP, $urandom_range(1, 24'h3ffff));
          reg_write(brz_pkg::REG_VSTEP, $urandom_range(1, 24'h3ffff));
        end
      endcase
      reg_write(brz_pkg::REG_COLOR_MODE, p % 2);
      ew = int'(eff_size(src_w, StoreW));
      eh = int'(eff_size(src_h, StoreH));
      for (r = 0; r < eh; r++)
        for (c = 0; c < ew; c++) begin
          send_word(wr_word(c, r, 24'($urandom)));
          px_written++;
        end
      for (int k = 0; k < 90; k++) begin
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          if ($urandom_range(0, 7) == 0)
            send_word(rd_word($urandom_range(0, 4095), $urandom_range(0, 4095)));
          else
            send_word(rd_word($urandom_range(0, 31), $urandom_range(0, 31)));
        end else if (sel < 85) begin
          send_word(wr_word($urandom_range(0, ew - 1), $urandom_range(0, eh - 1),
                            24'($urandom)));
        end else if ($urandom_range(0, 1)) begin
          send_word(wr_word($urandom_range(256, 4095), $urandom_range(0, 4095),
                            24'($urandom)));
        end else begin
          send_word(wr_word($urandom_range(0, 4095), $urandom_range(256, 4095),
                            24'($urandom)));
        end
      end
    end

    drain();
    $display("loaded %0d frame pixels over 10 register settings, checked %0d resampled pixels",
             px_written, px_checked);
    $display("covered gray and color modes, zero and full steps, edge clamping and stray writes");
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/brz_pkg.sv
rtl/core/brz_ram.sv
rtl/core/brz_map.sv
rtl/core/brz_blend.sv
rtl/core/bilinear_image_resize.sv
bench/tb_bilinear_image_resize.sv
